/* src/scan_code_set1_decoder_assert.svh */
// ---------------------------------------------------------------------------
// scan_code_set1_decoder_assert.svh
// Assertion macros for the set-1 scan code decoder. They are clocked on clk
// and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SCAN_CODE_SET1_DECODER_ASSERT_SVH
`define SCAN_CODE_SET1_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge out of reset.
`define SCD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true.
`define SCD_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SCD_ASSERT(name, prop, msg)
`define SCD_ASSERT_NEVER(name, cond, msg)

`endif

`endif

/* src/scd_pkg.sv */
// ---------------------------------------------------------------------------
// scd_pkg
// Types, codes and key classification helpers for the set-1 scan code decoder.
// ---------------------------------------------------------------------------
package scd_pkg;

    // Prefix and key codes
    localparam logic [7:0] CODE_E0     = 8'hE0;
    localparam logic [7:0] CODE_E1     = 8'hE1;
    localparam logic [7:0] CODE_PAUSE  = 8'hC5;
    localparam logic [7:0] CODE_EXT    = 8'h80;
    localparam logic [7:0] KEYPAD_LO   = 8'h47;
    localparam logic [7:0] KEYPAD_HI   = 8'h53;
    localparam logic [6:0] KEY_LCTRL   = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] KEY_ALT     = 7'h38;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [6:0] KEY_NUM     = 7'h45;
    localparam logic [6:0] KEY_SCROLL  = 7'h46;

    // Modifier bits: bit0 shift, bit1 alt, bit2 ctrl
    localparam logic [2:0] MOD_SHIFT   = 3'b001;
    localparam logic [2:0] MOD_ALT     = 3'b010;
    localparam logic [2:0] MOD_CTRL    = 3'b100;

    // Lock bits: bit0 scroll, bit1 num, bit2 caps
    localparam logic [2:0] LK_SCROLL   = 3'b001;
    localparam logic [2:0] LK_NUM      = 3'b010;
    localparam logic [2:0] LK_CAPS     = 3'b100;

    typedef enum logic [1:0] {
        PH_NONE,    // no prefix pending
        PH_E0,      // E0 seen
        PH_E1A,     // E1 seen, waiting for second byte
        PH_E1B      // E1 sequence, waiting for third byte
    } phase_t;

    typedef struct packed {
        logic [2:0] mods;
        logic [2:0] locks;
        phase_t     phase;
    } state_t;

    typedef struct packed {
        logic [7:0] key_index;
        logic       use_shift_table;
        logic       ctrl_held;
        logic       alt_held;
        logic       pause_break;
        logic [2:0] lock_flags;
    } result_t;

    function automatic logic [2:0] modifier_of(input logic [6:0] code);
        logic [2:0] m;
        m = 3'b000;
        if (code == KEY_LCTRL) m = MOD_CTRL;
        else if (code == KEY_LSHIFT || code == KEY_RSHIFT) m = MOD_SHIFT;
        else if (code == KEY_ALT) m = MOD_ALT;
        return m;
    endfunction

    function automatic logic [2:0] lock_of(input logic [6:0] code);
        logic [2:0] l;
        l = 3'b000;
        if (code == KEY_CAPS) l = LK_CAPS;
        else if (code == KEY_NUM) l = LK_NUM;
        else if (code == KEY_SCROLL) l = LK_SCROLL;
        return l;
    endfunction

endpackage

/* src/scd_chan_if.sv */
// ---------------------------------------------------------------------------
// scd_chan_if
// Valid/ready channels of the decoder: scan bytes in, key results out.
// ---------------------------------------------------------------------------
interface scd_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface scd_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_index;
    logic       use_shift_table;
    logic       ctrl_held;
    logic       alt_held;
    logic       pause_break;
    logic [2:0] lock_flags;

    modport source (output valid, output key_index, output use_shift_table,
                    output ctrl_held, output alt_held, output pause_break,
                    output lock_flags, input ready);
    modport sink   (input valid, input key_index, input use_shift_table,
                    input ctrl_held, input alt_held, input pause_break,
                    input lock_flags, output ready);
endinterface

/* src/scd_decode.sv */
// ---------------------------------------------------------------------------
// scd_decode
// Single-pass decode of one scan byte: next prefix/modifier/lock state and
// the key result, if the byte produces one.
// ---------------------------------------------------------------------------
module scd_decode
    import scd_pkg::*;
(
    input  logic [7:0] scan_byte,
    input  state_t     cur,
    output state_t     nxt,
    output logic       has_result,
    output result_t    result
);

    logic [6:0] base;
    logic [2:0] mod_hit;
    logic [2:0] lock_hit;
    logic [7:0] idx;
    logic       keypad;

    assign base     = scan_byte[6:0];
    assign mod_hit  = modifier_of(base);
    assign lock_hit = lock_of(base);

    // Ordinary key index; E0, or a keypad key with num lock off, moves it to the upper half
    always_comb
    begin
        idx = {(cur.phase == PH_E0), base};
        keypad = (idx >= KEYPAD_LO) && (idx <= KEYPAD_HI) && ((cur.locks & LK_NUM) == 3'b000);
        if (keypad)
        begin
            idx = idx | CODE_EXT;
        end
    end

    // State update and result
    always_comb
    begin
        nxt        = cur;
        has_result = 1'b0;
        result     = '0;
        result.lock_flags = cur.locks;
        case (cur.phase)
            PH_E1B:
            begin
                nxt.phase = PH_NONE;
                if (scan_byte == CODE_PAUSE)
                begin
                    has_result         = 1'b1;
                    result.pause_break = 1'b1;
                end
            end
            PH_E1A:
            begin
                nxt.phase = PH_E1B;
            end
            default:
            begin
                if (scan_byte == CODE_E1)
                begin
                    nxt.phase = PH_E1A;
                end
                else if (scan_byte == CODE_E0)
                begin
                    nxt.phase = PH_E0;
                end
                else
                begin
                    nxt.phase = PH_NONE;
                    if (scan_byte[7])
                    begin
                        // release: clear modifier, toggle lock
                        nxt.mods  = cur.mods & ~mod_hit;
                        nxt.locks = cur.locks ^ lock_hit;
                    end
                    else if (lock_hit != 3'b000)
                    begin
                        // lock press does nothing
                    end
                    else if (mod_hit != 3'b000)
                    begin
                        nxt.mods = cur.mods | mod_hit;
                    end
                    else
                    begin
                        has_result             = 1'b1;
                        result.key_index       = idx;
                        result.use_shift_table = keypad ? 1'b0
                                                 : ((cur.mods & MOD_SHIFT) != 3'b000)
                                                   ^ ((cur.locks & LK_CAPS) != 3'b000);
                        result.ctrl_held       = (cur.mods & MOD_CTRL) != 3'b000;
                        result.alt_held        = (cur.mods & MOD_ALT) != 3'b000;
                    end
                end
            end
        endcase
    end

endmodule

/* src/scan_code_set1_decoder.sv */
// ---------------------------------------------------------------------------
// scan_code_set1_decoder
// Set-1 keyboard scan code decoder: prefix, modifier and lock tracking with
// one normalized key result per pressed ordinary key.
// ---------------------------------------------------------------------------
// Each scan byte is registered in the input register, decoded combinationally
// and its result, if any, is registered on the output channel; a new byte is
// accepted every cycle unless stalled. The only stall comes from a full result
// register whose result is not yet taken, and only a byte that produces a
// result waits on it. Prefixes, modifier and lock keys and key releases give
// no result; the Pause sequence E1 xx C5 gives one result with pause_break
// set. Num lock is on after reset.
// ---------------------------------------------------------------------------
`include "scan_code_set1_decoder_assert.svh"

module scan_code_set1_decoder
    import scd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    scd_scan_if.sink     scan_in,
    scd_key_if.source    key_out
);

    localparam state_t STATE_RESET = '{mods: 3'b000, locks: LK_NUM, phase: PH_NONE};

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       out_vld_reg;
    logic       out_vld_next;
    result_t    out_res_reg;

    state_t     dec_state;
    logic       dec_has;
    result_t    dec_res;
    logic       out_free;
    logic       advance;

    scd_decode u_decode (
        .scan_byte  (in_byte_reg),
        .cur        (state_reg),
        .nxt        (dec_state),
        .has_result (dec_has),
        .result     (dec_res)
    );

    // Handshake control
    assign out_free      = !out_vld_reg || key_out.ready;
    assign advance       = in_vld_reg && (!dec_has || out_free);
    assign scan_in.ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next  = scan_in.ready ? scan_in.valid : in_vld_reg;
        state_next   = advance ? dec_state : state_reg;
        out_vld_next = (advance && dec_has) ? 1'b1
                       : (key_out.ready ? 1'b0 : out_vld_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            state_reg   <= STATE_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (scan_in.valid && scan_in.ready)
        begin
            in_byte_reg <= scan_in.scan_byte;
        end
        if (advance && dec_has)
        begin
            out_res_reg <= dec_res;
        end
    end

    assign key_out.valid           = out_vld_reg;
    assign key_out.key_index       = out_res_reg.key_index;
    assign key_out.use_shift_table = out_res_reg.use_shift_table;
    assign key_out.ctrl_held       = out_res_reg.ctrl_held;
    assign key_out.alt_held        = out_res_reg.alt_held;
    assign key_out.pause_break     = out_res_reg.pause_break;
    assign key_out.lock_flags      = out_res_reg.lock_flags;

    // Assertions
    `SCD_ASSERT(a_state_holds, !advance |=> $stable(state_reg), "state changed without a byte")
    `SCD_ASSERT(a_e1_second, advance && state_reg.phase == PH_E1A |=> state_reg.phase == PH_E1B, "E1 sequence did not advance")
    `SCD_ASSERT_NEVER(a_no_overwrite, scan_in.valid && scan_in.ready && in_vld_reg && !advance, "input register overwritten")
    `SCD_ASSERT_NEVER(a_pause_clean, out_vld_reg && out_res_reg.pause_break && (out_res_reg.key_index != 8'h00 || out_res_reg.ctrl_held || out_res_reg.alt_held || out_res_reg.use_shift_table), "pause result carries key data")

endmodule

/* test/scd_key_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// scd_key_checker
// Watches the scan byte and key result channels of the set-1 decoder. Every
// accepted scan byte is run through an independent model of the prefix,
// modifier and lock tracking. Every accepted key result is compared field by
// field with the oldest predicted one.
// ---------------------------------------------------------------------------
module scd_key_checker
    import scd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    scd_scan_if   scan,
    scd_key_if    keys,
    output int    mismatches,
    output int    expected_left,
    output int    keys_checked,
    output int    pause_count,
    output int    remap_count
);

    localparam int PRINT_CAP = 40;

    // Model state
    logic [2:0] mods_q;
    logic [2:0] locks_q;
    phase_t     scan_phase;

    result_t    key_queue[$];

    // One line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the model by one scan byte; returns 1 when a key result follows
    function automatic bit predict_key(input logic [7:0] b, output result_t r);
        logic [7:0] idx;
        logic [2:0] mbit;
        logic [2:0] lbit;
        bit         was_e0;
        r = '0;

        // E1 sequence: second byte is swallowed, third byte ends it
        if (scan_phase == PH_E1B) begin
            scan_phase = PH_NONE;
            if (b != CODE_PAUSE) return 1'b0;
            r.pause_break = 1'b1;
            r.lock_flags  = locks_q;
            pause_count++;
            return 1'b1;
        end
        if (scan_phase == PH_E1A) begin
            scan_phase = PH_E1B;
            return 1'b0;
        end

        // Prefix bytes; E1 drops a pending E0
        if (b == CODE_E1) begin
            scan_phase = PH_E1A;
            return 1'b0;
        end
        if (b == CODE_E0) begin
            scan_phase = PH_E0;
            return 1'b0;
        end
        was_e0     = (scan_phase == PH_E0);
        scan_phase = PH_NONE;

        mbit = '0;
        lbit = '0;
        case (b[6:0])
            KEY_LCTRL:              mbit = MOD_CTRL;
            KEY_LSHIFT, KEY_RSHIFT: mbit = MOD_SHIFT;
            KEY_ALT:                mbit = MOD_ALT;
            KEY_CAPS:               lbit = LK_CAPS;
            KEY_NUM:                lbit = LK_NUM;
            KEY_SCROLL:             lbit = LK_SCROLL;
            default: ;
        endcase

        // Release: drop modifier, toggle lock
        if (b[7]) begin
            mods_q  = mods_q & ~mbit;
            locks_q = locks_q ^ lbit;
            return 1'b0;
        end
        if (lbit != '0) return 1'b0;
        if (mbit != '0) begin
            mods_q = mods_q | mbit;
            return 1'b0;
        end

        // Ordinary key press
        idx = b;
        if (was_e0) idx = idx | CODE_EXT;
        if (idx >= KEYPAD_LO && idx <= KEYPAD_HI && (locks_q & LK_NUM) == '0) begin
            idx = idx | CODE_EXT;
            r.use_shift_table = 1'b0;
            remap_count++;
        end
        else begin
            r.use_shift_table = ((mods_q & MOD_SHIFT) != '0) ^ ((locks_q & LK_CAPS) != '0);
        end
        r.key_index  = idx;
        r.ctrl_held  = (mods_q & MOD_CTRL) != '0;
        r.alt_held   = (mods_q & MOD_ALT) != '0;
        r.lock_flags = locks_q;
        return 1'b1;
    endfunction

    // Compare results, then predict from the byte taken at the same edge
    always @(posedge clk) begin
        result_t got;
        result_t want;
        result_t fresh;
        if (!rst_n) begin
            mods_q        = '0;
            locks_q       = LK_NUM;
            scan_phase    = PH_NONE;
            key_queue.delete();
            mismatches    = 0;
            keys_checked  = 0;
            pause_count   = 0;
            remap_count   = 0;
            expected_left <= 0;
        end
        else begin
            if (keys.valid && keys.ready) begin
                got.key_index       = keys.key_index;
                got.use_shift_table = keys.use_shift_table;
                got.ctrl_held       = keys.ctrl_held;
                got.alt_held        = keys.alt_held;
                got.pause_break     = keys.pause_break;
                got.lock_flags      = keys.lock_flags;
                if (key_queue.size() == 0) begin
                    report_mismatch("unexpected key result", got, 0);
                end
                else begin
                    want = key_queue.pop_front();
                    keys_checked++;
                    if (got.key_index !== want.key_index)
                        report_mismatch("key_index", got.key_index, want.key_index);
                    if (got.use_shift_table !== want.use_shift_table)
                        report_mismatch("use_shift_table", got.use_shift_table,
                                        want.use_shift_table);
                    if (got.ctrl_held !== want.ctrl_held)
                        report_mismatch("ctrl_held", got.ctrl_held, want.ctrl_held);
                    if (got.alt_held !== want.alt_held)
                        report_mismatch("alt_held", got.alt_held, want.alt_held);
                    if (got.pause_break !== want.pause_break)
                        report_mismatch("pause_break", got.pause_break, want.pause_break);
                    if (got.lock_flags !== want.lock_flags)
                        report_mismatch("lock_flags", got.lock_flags, want.lock_flags);
                end
            end
            if (scan.valid && scan.ready) begin
                if (predict_key(scan.scan_byte, fresh))
                    key_queue.push_back(fresh);
            end
            expected_left <= key_queue.size();
        end
    end

endmodule

/* test/scan_code_set1_decoder_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// scan_code_set1_decoder_tb
// Drives scan bytes into the set-1 decoder: a directed opening over prefixes,
// modifiers, locks, keypad remap and the Pause sequence, then weighted random
// key traffic. Sender bursts and receiver stalls vary throughout; the
// checker beside the block predicts and compares every key result.
// ---------------------------------------------------------------------------
module scan_code_set1_decoder_tb;
    import scd_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_LIMIT  = 5000;

    // Receiver stall modes
    localparam int RX_OPEN   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;

    logic clk = 1'b0;
    logic rst_n;

    scd_scan_if scan_if ();
    scd_key_if  key_if ();

    int mismatches;
    int expected_left;
    int keys_checked;
    int pause_count;
    int remap_count;

    int items_sent;
    int burst_left;
    bit hold_off_req;
    bit hold_off_done;

    scan_code_set1_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_if),
        .key_out (key_if)
    );

    scd_key_checker key_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .scan          (scan_if),
        .keys          (key_if),
        .mismatches    (mismatches),
        .expected_left (expected_left),
        .keys_checked  (keys_checked),
        .pause_count   (pause_count),
        .remap_count   (remap_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Safety net
    initial
    begin
        #5_000_000;
        $display("[scan_code_set1_decoder] ERROR");
        $finish;
    end

    // Offer one byte, hold it until taken; gaps between bursts
    task automatic send(input logic [7:0] b);
        scan_if.valid     <= 1'b1;
        scan_if.scan_byte <= b;
        do @(posedge clk); while (scan_if.ready !== 1'b1);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            scan_if.valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic key_down(input logic [6:0] k);
        send({1'b0, k});
    endtask

    task automatic key_up(input logic [6:0] k);
        send({1'b1, k});
    endtask

    // Stop offering and wait for every predicted result, bounded
    task automatic wait_drained(input int max_cycles);
        int n;
        n = 0;
        scan_if.valid <= 1'b0;
        do begin
            @(posedge clk);
            n++;
        end while (expected_left != 0 && n < max_cycles);
    endtask

    // Result receiver with its own stall pattern and one long hold-off
    initial
    begin : result_taker
        int mode;
        int mode_left;
        key_if.ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                key_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_OPEN, RX_SPARSE);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: key_if.ready <= 1'b1;
                    RX_HALF: key_if.ready <= 1'($urandom_range(0, 1));
                    default: key_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int kind;
        logic [6:0] k;
        rst_n             = 1'b0;
        scan_if.valid     = 1'b0;
        scan_if.scan_byte = '0;
        items_sent        = 0;
        burst_left        = $urandom_range(1, 40);
        hold_off_req      = 1'b0;
        hold_off_done     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: code extremes, num lock off keypad remap, caps and shift,
        // E0 extension, lock press ignored, E1 over E0, third byte not C5,
        // Pause, scroll toggle, release of 7F
        send(8'h00);
        send(8'h7F);
        send(KEYPAD_LO);
        key_up(KEY_NUM);
        send(KEYPAD_LO);
        key_down(KEY_CAPS);
        key_up(KEY_CAPS);
        key_down(KEY_LSHIFT);
        send(8'h1E);
        key_up(KEY_LSHIFT);
        key_down(KEY_LCTRL);
        key_down(KEY_ALT);
        send(CODE_E0);
        send(8'h48);
        key_up(KEY_LCTRL);
        key_up(KEY_ALT);
        send(CODE_E0);
        send(CODE_E1);
        send({1'b1, KEY_LCTRL});
        send({1'b0, KEY_NUM});
        send(CODE_E1);
        send({1'b0, KEY_LCTRL});
        send(CODE_PAUSE);
        key_up(KEY_SCROLL);
        send(8'hFF);
        wait_drained(DRAIN_LIMIT);

        // Random traffic; the receiver holds off once early on
        hold_off_req = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) wait_drained(DRAIN_LIMIT);
            kind = $urandom_range(0, 99);
            if (kind < 42) begin
                send(8'($urandom_range(0, 127)));
            end
            else if (kind < 52) begin
                send(CODE_E0);
                send(8'($urandom_range(0, 255)));
            end
            else if (kind < 62) begin
                case ($urandom_range(0, 3))
                    0:       k = KEY_LCTRL;
                    1:       k = KEY_LSHIFT;
                    2:       k = KEY_RSHIFT;
                    default: k = KEY_ALT;
                endcase
                send({$urandom_range(0, 1) == 1, k});
            end
            else if (kind < 69) begin
                case ($urandom_range(0, 2))
                    0:       k = KEY_CAPS;
                    1:       k = KEY_NUM;
                    default: k = KEY_SCROLL;
                endcase
                send({$urandom_range(0, 3) != 0, k});
            end
            else if (kind < 77) begin
                send(8'($urandom_range(KEYPAD_LO, KEYPAD_HI)));
            end
            else if (kind < 83) begin
                send(CODE_E1);
                send(($urandom_range(0, 1) != 0) ? {1'b0, KEY_LCTRL}
                                                 : 8'($urandom_range(0, 255)));
                send(CODE_PAUSE);
            end
            else if (kind < 88) begin
                send(CODE_E1);
                send(8'($urandom_range(0, 255)));
                send(8'($urandom_range(0, 255)));
            end
            else begin
                send(8'($urandom_range(0, 255)));
            end
        end

        // Wrap-up
        wait_drained(DRAIN_LIMIT);
        repeat (10) @(posedge clk);
        $display("Run covered %0d scan bytes: directed prefix, modifier, lock and Pause cases",
                 items_sent);
        $display("plus random traffic; %0d key results checked, %0d Pause, %0d keypad remaps",
                 keys_checked, pause_count, remap_count);
        if (mismatches == 0 && expected_left == 0)
            $display("[scan_code_set1_decoder] OK");
        else
            $display("[scan_code_set1_decoder] ERROR");
        $finish;
    end

endmodule
